// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define CKS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define CKS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CKS_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/cks_pkg.sv -----
// shared types, constants and round functions of the keystream block
package cks_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    // each double round is four half quarter-round steps
    localparam int ROUND_STEPS   = 4 * DOUBLE_ROUNDS;
    localparam int RSTEP_W       = $clog2(ROUND_STEPS);
    localparam int NUM_WORDS     = 16;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 4;
    localparam int WANT_W        = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_PART_0 = 3'd0,
        CFG_KEY_PART_1 = 3'd1,
        CFG_KEY_PART_2 = 3'd2,
        CFG_KEY_PART_3 = 3'd3,
        CFG_NONCE_LOW  = 3'd4,
        CFG_NONCE_HIGH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    typedef struct packed {
        logic               load;
        logic               step;
        logic               restart;
        logic               finish;
        logic [RSTEP_W-1:0] round_step;
        logic [IDX_W-1:0]   emit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic counter_zero;
    } t_dp_status;

    function automatic t_word rotl(t_word v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // one half of a quarter round: two add/xor/rotate lines
    function automatic t_quad qr_half(t_quad q, logic second);
        t_quad r;
        r.a = q.a + q.b;
        r.d = second ? rotl(q.d ^ r.a, 8) : rotl(q.d ^ r.a, 16);
        r.c = q.c + r.d;
        r.b = second ? rotl(q.b ^ r.c, 7) : rotl(q.b ^ r.c, 12);
        return r;
    endfunction

endpackage

// ----- hw/rtl/cks_in_if.sv -----
// request channel: one item asks for one keystream block
interface cks_in_if;
    import cks_pkg::*;
    logic              valid;
    logic              ready;
    logic              restart;
    logic [WANT_W-1:0] words_wanted;

    modport source (output valid, restart, words_wanted, input ready);
    modport sink   (input valid, restart, words_wanted, output ready);
endinterface

// ----- hw/rtl/cks_out_if.sv -----
// result channel: one keystream word or an overflow marker per item
interface cks_out_if;
    import cks_pkg::*;
    logic             valid;
    logic             ready;
    logic [WORD_W-1:0] keystream_word;
    logic [IDX_W-1:0]  word_index;
    logic             last;
    logic             counter_overflow;

    modport source (output valid, keystream_word, word_index, last, counter_overflow,
                    input ready);
    modport sink   (input valid, keystream_word, word_index, last, counter_overflow,
                    output ready);
endinterface

// ----- hw/rtl/chacha20_keystream_block_top.sv -----
// chacha20 keystream block generator, top level
// One request item yields one 64-byte ChaCha20 block (key, counter, nonce layout as in
// the RFC 8439 block function) and emits its first words_wanted words (1 to 16, values
// above 16 saturate, zero emits nothing) low word first, with last on the final one.
// The block counter starts at 1 after reset, advances once per computed block and is
// set back to 1 by restart. Once it has wrapped to zero every request gives one item
// with counter_overflow set and all data fields zero, until a restart.
// A request is taken only when the block is idle. The rounds run on one shared set
// of four quarter-round units, each doing half a quarter round per cycle, for the
// 10 double rounds; then the ST_FINAL step adds the starting state, and then one word
// leaves per cycle while the sink is ready.
// Key and nonce are written through the config port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module chacha20_keystream_block_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cks_in_if.sink                           i_req,
    cks_out_if.source                        o_ks,
    input  logic                             i_cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cks_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cks_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_word      dp_word;

    // sequencer owns both handshakes
    cks_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_ks     (o_ks),
        .i_word   (dp_word),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // state words, round logic and config registers
    cks_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_word      (dp_word)
    );

endmodule

// ----- hw/rtl/cks_datapath.sv -----
// key/nonce registers, block counter, working state and shared round logic
module cks_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cks_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  cks_pkg::t_dp_cmd                 i_cmd,
    output cks_pkg::t_dp_status              o_status,
    output cks_pkg::t_word                   o_word
);
    import cks_pkg::*;

    logic [CFG_DATA_W-1:0] r_key0, r_key1, r_key2, r_key3, r_nonce_lo;
    logic [WORD_W-1:0]     r_nonce_hi;
    t_word                 r_counter;
    t_word                 r_x [NUM_WORDS];
    t_word                 n_x [NUM_WORDS];
    t_word                 init [NUM_WORDS];
    t_quad                 col_in  [4];
    t_quad                 dia_in  [4];
    t_quad                 q_in    [4];
    t_quad                 q_out   [4];
    logic                  diag;
    logic                  second;

    assign second = i_cmd.round_step[0];
    assign diag   = i_cmd.round_step[1];

    // starting state; restart takes effect in the same cycle as the load
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init[i] = SIGMA[i];
        end
        init[4]  = r_key0[WORD_W-1:0];
        init[5]  = r_key0[CFG_DATA_W-1:WORD_W];
        init[6]  = r_key1[WORD_W-1:0];
        init[7]  = r_key1[CFG_DATA_W-1:WORD_W];
        init[8]  = r_key2[WORD_W-1:0];
        init[9]  = r_key2[CFG_DATA_W-1:WORD_W];
        init[10] = r_key3[WORD_W-1:0];
        init[11] = r_key3[CFG_DATA_W-1:WORD_W];
        init[12] = i_cmd.restart ? t_word'(1) : r_counter;
        init[13] = r_nonce_lo[WORD_W-1:0];
        init[14] = r_nonce_lo[CFG_DATA_W-1:WORD_W];
        init[15] = r_nonce_hi;
    end

    // four shared quarter-round units, fed with column or diagonal grouping
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            col_in[i] = '{a: r_x[i], b: r_x[4 + i], c: r_x[8 + i], d: r_x[12 + i]};
            dia_in[i] = '{a: r_x[i], b: r_x[4 + ((i + 1) % 4)],
                          c: r_x[8 + ((i + 2) % 4)], d: r_x[12 + ((i + 3) % 4)]};
            q_in[i]   = diag ? dia_in[i] : col_in[i];
            q_out[i]  = qr_half(q_in[i], second);
        end
        for (int i = 0; i < 4; i++) begin
            if (diag) begin
                n_x[i]                  = q_out[i].a;
                n_x[4 + ((i + 1) % 4)]  = q_out[i].b;
                n_x[8 + ((i + 2) % 4)]  = q_out[i].c;
                n_x[12 + ((i + 3) % 4)] = q_out[i].d;
            end else begin
                n_x[i]      = q_out[i].a;
                n_x[4 + i]  = q_out[i].b;
                n_x[8 + i]  = q_out[i].c;
                n_x[12 + i] = q_out[i].d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0     <= '0;
            r_key1     <= '0;
            r_key2     <= '0;
            r_key3     <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_counter  <= t_word'(1);
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_KEY_PART_0: r_key0     <= i_cfg_data;
                    CFG_KEY_PART_1: r_key1     <= i_cfg_data;
                    CFG_KEY_PART_2: r_key2     <= i_cfg_data;
                    CFG_KEY_PART_3: r_key3     <= i_cfg_data;
                    CFG_NONCE_LOW:  r_nonce_lo <= i_cfg_data;
                    CFG_NONCE_HIGH: r_nonce_hi <= i_cfg_data[WORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.restart) begin
                r_counter <= t_word'(1);
            end else if (i_cmd.finish) begin
                r_counter <= r_counter + t_word'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= init;
        end else if (i_cmd.step) begin
            r_x <= n_x;
        end else if (i_cmd.finish) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_x[i] <= r_x[i] + init[i];
            end
        end
    end

    assign o_status.counter_zero = (r_counter == '0);
    assign o_word                = r_x[i_cmd.emit_idx];

    `include "assert_macros.svh"

    `CKS_ASSERT(a_counter_advance, i_clk, i_rst_n,
        i_cmd.finish |=> (r_counter == $past(r_counter) + t_word'(1)),
        "counter did not advance after block")
    `CKS_ASSERT(a_counter_restart, i_clk, i_rst_n,
        i_cmd.restart |=> (r_counter == t_word'(1)),
        "restart did not set counter to one")
    `CKS_NEVER(a_cmd_exclusive, i_clk, i_rst_n,
        i_cmd.load && (i_cmd.step || i_cmd.finish),
        "load overlaps round or finish")

endmodule

// ----- hw/rtl/cks_ctrl.sv -----
// sequencer: request intake, round stepping and word emission
module cks_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cks_in_if.sink               i_req,
    cks_out_if.source            o_ks,
    input  cks_pkg::t_word       i_word,
    input  cks_pkg::t_dp_status  i_status,
    output cks_pkg::t_dp_cmd     o_cmd
);
    import cks_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FINAL = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_OVFL  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [RSTEP_W-1:0] r_step, n_step;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_last, n_last;
    logic               in_acc, out_acc, ctr_zero;
    logic [WANT_W-1:0]  want_sat;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_acc     = o_ks.valid && o_ks.ready;
    assign ctr_zero    = !i_req.restart && i_status.counter_zero;
    assign want_sat    = (i_req.words_wanted > WANT_W'(NUM_WORDS)) ?
                         WANT_W'(NUM_WORDS) : i_req.words_wanted;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pos   = r_pos;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.round_step = r_step;
        o_cmd.emit_idx   = r_pos;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.restart = i_req.restart;
                    if (ctr_zero) begin
                        n_state = ST_OVFL;
                    end else if (want_sat != '0) begin
                        o_cmd.load = 1'b1;
                        n_last     = IDX_W'(want_sat - WANT_W'(1));
                        n_step     = '0;
                        n_state    = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.step = 1'b1;
                if (r_step == RSTEP_W'(ROUND_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_FINAL;
                end else begin
                    n_step = r_step + RSTEP_W'(1);
                end
            end
            ST_FINAL: begin
                o_cmd.finish = 1'b1;
                n_pos        = '0;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (r_pos == r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos + IDX_W'(1);
                    end
                end
            end
            ST_OVFL: begin
                if (out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_pos   <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pos   <= n_pos;
            r_last  <= n_last;
        end
    end

    assign o_ks.valid            = (r_state == ST_EMIT) || (r_state == ST_OVFL);
    assign o_ks.counter_overflow = (r_state == ST_OVFL);
    assign o_ks.keystream_word   = (r_state == ST_EMIT) ? i_word : '0;
    assign o_ks.word_index       = (r_state == ST_EMIT) ? r_pos : '0;
    assign o_ks.last             = (r_state == ST_EMIT) && (r_pos == r_last);

    `include "assert_macros.svh"

    `CKS_ASSERT(a_pos_in_range, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (r_pos <= r_last), "emit position beyond last word")
    `CKS_ASSERT(a_final_to_emit, i_clk, i_rst_n, (r_state == ST_FINAL) |=> ((r_state == ST_EMIT) && (r_pos == '0)), "emission did not start at word zero")
    `CKS_ASSERT(a_step_parked, i_clk, i_rst_n, (r_state != ST_ROUND) |-> (r_step == '0), "round counter not parked outside rounds")

endmodule
